// File: hw/rtl/ddj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddj_pkg
// Shared types and constants of the deadline job dispatcher.
// ----------------------------------------------------------------------------
package ddj_pkg;

  // fixed field widths of the request and response beats
  localparam int SLOT_BITS = 6;
  localparam int TIME_BITS = 48;
  localparam int MISS_BITS = 7;

  // default sizing of the job table and the time base
  localparam int DEF_MAX_JOBS   = 64;
  localparam int DEF_TIME_WIDTH = 48;

  // request operation codes
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_CLEAR    = 2'd2
  } op_e;

  // response status codes
  typedef enum logic [1:0] {
    ST_ACK        = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_EMPTY      = 2'd2
  } status_e;

  typedef struct packed {
    op_e                  operation;
    logic [SLOT_BITS-1:0] slot;
    logic [TIME_BITS-1:0] arrival_time;
    logic [TIME_BITS-1:0] service_time;
    logic [TIME_BITS-1:0] deadline_time;
  } job_req_t;

  typedef struct packed {
    status_e              status;
    logic [SLOT_BITS-1:0] chosen_slot;
    logic [TIME_BITS-1:0] finish_time;
    logic [TIME_BITS-1:0] job_latency;
    logic                 deadline_missed;
    logic [MISS_BITS-1:0] miss_total;
  } job_rsp_t;

endpackage

// File: hw/rtl/deadline_job_dispatcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_job_dispatcher_unit
// Job table with a simulated clock; dispatches the lowest arrived pending slot or the
// earliest deadline by sequential scans of the table memory.
// ----------------------------------------------------------------------------
//
//  channel   | ports                          | handshake
//  ----------+--------------------------------+-----------------------------
//  request   | start, busy, req_i             | beat taken when start & !busy
//  response  | done_o, rsp_o                  | one-cycle strobe, no stall
//  config    | cfg_we_i, cfg_wdata_i          | write when cfg_we_i is high
//
//  load, clear and unused codes: response on the next cycle.
//  dispatch with nothing pending: response on the next cycle. Otherwise
//  the table memory is scanned one entry per cycle through its single read
//  port; a second scan follows when the clock must jump to the earliest
//  arrival. Reset clears the pending marks, the clock and the miss count at
//  once; the table memory itself is not cleared. The receiver cannot stall
//  responses.
//
module deadline_job_dispatcher_unit #(
  parameter int MAX_JOBS   = ddj_pkg::DEF_MAX_JOBS,
  parameter int TIME_WIDTH = ddj_pkg::DEF_TIME_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ddj_pkg::job_req_t req_i,
  output logic              done_o,
  output ddj_pkg::job_rsp_t rsp_o,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);
  import ddj_pkg::*;

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int TW    = TIME_WIDTH;
  localparam int ENT_W = 3 * TW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_ADD  = 5'b00100,
    S_DONE = 5'b01000,
    S_NONE = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 pass_q, pass_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  logic [TW-1:0]        best_arr_q, best_arr_d;
  logic [TW-1:0]        best_dl_q, best_dl_d;
  logic                 ear_found_q, ear_found_d;
  logic [TW-1:0]        ear_q, ear_d;
  logic [TW-1:0]        clock_q, clock_d;
  logic [MISS_BITS-1:0] miss_q, miss_d;
  logic [MAX_JOBS-1:0]  pending_q, pending_d;
  logic                 edf_q;
  logic                 done_q, done_d;
  job_rsp_t             rsp_q, rsp_d;

  logic                 accept;
  logic                 clear_acc;
  logic                 mem_we;
  logic [IDX_W-1:0]     wr_idx;
  logic [ENT_W-1:0]     wr_data;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENT_W-1:0]     rd_q;
  logic [ENT_W-1:0]     mem_q [MAX_JOBS];
  logic [TW-1:0]        rd_arr, rd_svc, rd_dl;
  logic                 elig;
  logic [TW:0]          sum;
  logic [TW-1:0]        latency;
  logic                 missed;
  logic                 pass_end;

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign clear_acc = accept && (req_i.operation == OP_CLEAR);
  assign done_o    = done_q;
  assign rsp_o     = rsp_q;

  // job table memory: arrival, service, deadline per entry
  assign wr_idx  = IDX_W'(req_i.slot);
  assign wr_data = {TW'(req_i.arrival_time), TW'(req_i.service_time),
                    TW'(req_i.deadline_time)};
  assign rd_arr  = rd_q[3*TW-1:2*TW];
  assign rd_svc  = rd_q[2*TW-1:TW];
  assign rd_dl   = rd_q[TW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  // scan bookkeeping
  assign pass_end = (cnt_q == CNT_W'(MAX_JOBS)) && !cmp_vld_q;
  assign elig     = pending_q[cmp_idx_q] && (rd_arr <= clock_q);

  // finish arithmetic: clock plus service adder, latency and deadline compare
  assign sum     = {1'b0, clock_q} + {1'b0, rd_svc};
  assign latency = clock_q - best_arr_q;
  assign missed  = clock_q > best_dl_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cnt_q[IDX_W-1:0];
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_arr_d  = best_arr_q;
    best_dl_d   = best_dl_q;
    ear_found_d = ear_found_q;
    ear_d       = ear_q;
    clock_d     = clock_q;
    miss_d      = miss_q;
    pending_d   = pending_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    mem_we      = 1'b0;
    rd_addr     = cnt_q[IDX_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rsp_d.status          = ST_ACK;
          rsp_d.chosen_slot     = '0;
          rsp_d.finish_time     = '0;
          rsp_d.job_latency     = '0;
          rsp_d.deadline_missed = 1'b0;
          rsp_d.miss_total      = miss_q;
          done_d                = 1'b1;
          unique case (req_i.operation)
            OP_LOAD: begin
              if (32'(req_i.slot) < MAX_JOBS) begin
                mem_we            = 1'b1;
                pending_d[wr_idx] = 1'b1;
              end
            end
            OP_CLEAR: begin
              pending_d        = '0;
              clock_d          = '0;
              miss_d           = '0;
              rsp_d.miss_total = '0;
            end
            OP_DISPATCH: begin
              if (pending_q == '0) begin
                rsp_d.status = ST_EMPTY;
              end else begin
                done_d      = 1'b0;
                state_d     = S_SCAN;
                cnt_d       = '0;
                pass_d      = 1'b0;
                found_d     = 1'b0;
                ear_found_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // issue one table read per cycle
        if (cnt_q < CNT_W'(MAX_JOBS)) begin
          cmp_vld_d = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
        end
        // evaluate the entry read on the previous cycle
        if (cmp_vld_q) begin
          if (elig && (!found_q || (edf_q && (rd_dl < best_dl_q)))) begin
            found_d    = 1'b1;
            best_idx_d = cmp_idx_q;
            best_arr_d = rd_arr;
            best_dl_d  = rd_dl;
          end
          if (pending_q[cmp_idx_q] && (!ear_found_q || (rd_arr < ear_q))) begin
            ear_found_d = 1'b1;
            ear_d       = rd_arr;
          end
        end
        if (pass_end) begin
          if (found_q) begin
            rd_addr = best_idx_q;
            state_d = S_ADD;
          end else if (!pass_q && ear_found_q) begin
            clock_d = ear_q;
            pass_d  = 1'b1;
            cnt_d   = '0;
          end else begin
            state_d = S_NONE;
          end
        end
      end

      S_ADD: begin
        // run the chosen job, saturating the clock
        clock_d = sum[TW] ? '1 : sum[TW-1:0];
        state_d = S_DONE;
      end

      S_DONE: begin
        if (missed && (miss_q != '1)) begin
          miss_d = miss_q + MISS_BITS'(1);
        end
        pending_d[best_idx_q] = 1'b0;
        rsp_d.status          = ST_DISPATCHED;
        rsp_d.chosen_slot     = SLOT_BITS'(best_idx_q);
        rsp_d.finish_time     = TIME_BITS'(clock_q);
        rsp_d.job_latency     = TIME_BITS'(latency);
        rsp_d.deadline_missed = missed;
        rsp_d.miss_total      = (missed && (miss_q != '1)) ? miss_q + MISS_BITS'(1)
                                                           : miss_q;
        done_d                = 1'b1;
        state_d               = S_IDLE;
      end

      S_NONE: begin
        rsp_d.status          = ST_EMPTY;
        rsp_d.chosen_slot     = '0;
        rsp_d.finish_time     = '0;
        rsp_d.job_latency     = '0;
        rsp_d.deadline_missed = 1'b0;
        rsp_d.miss_total      = miss_q;
        done_d                = 1'b1;
        state_d               = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pass_q      <= 1'b0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      ear_found_q <= 1'b0;
      clock_q     <= '0;
      miss_q      <= '0;
      pending_q   <= '0;
      edf_q       <= 1'b1;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pass_q      <= pass_d;
      cmp_vld_q   <= cmp_vld_d;
      found_q     <= found_d;
      ear_found_q <= ear_found_d;
      clock_q     <= clock_d;
      miss_q      <= miss_d;
      pending_q   <= pending_d;
      done_q      <= done_d;
      if (cfg_we_i) begin
        edf_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    best_idx_q <= best_idx_d;
    best_arr_q <= best_arr_d;
    best_dl_q  <= best_dl_d;
    ear_q      <= ear_d;
    rsp_q      <= rsp_d;
  end

  // checks
  a_simple_op_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.operation != OP_DISPATCH)) |=> done_o)
    else $error("load or clear beat did not answer on the next cycle");

  a_empty_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.operation == OP_DISPATCH) && (pending_q == '0))
      |=> (done_o && (rsp_o.status == ST_EMPTY)))
    else $error("dispatch with empty table did not report empty");

  a_chosen_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> pending_q[best_idx_q])
    else $error("dispatched job was not pending");

  a_miss_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (miss_q < $past(miss_q)) |-> $past(clear_acc))
    else $error("miss count dropped without a clear");

endmodule
